### src/tsp_pkg.sv
// Shared types, codes, defaults and the helper function of the tone sequence player.
`default_nettype none

package tsp_pkg;

   // Default sizes of the stores and of the command walk.
   localparam int DEF_SEQ_DEPTH     = 256;
   localparam int DEF_VOICE_ENTRIES = 32;
   localparam int DEF_MAX_COMMANDS  = 8;

   // Input function codes.
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_STEP  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   // Table select codes.
   localparam logic [2:0] SEL_SEQ   = 3'd0;
   localparam logic [2:0] SEL_DUR   = 3'd1;
   localparam logic [2:0] SEL_FREQ1 = 3'd2;
   localparam logic [2:0] SEL_FREQ2 = 3'd3;
   localparam logic [2:0] SEL_FREQ3 = 3'd4;
   localparam logic [2:0] SEL_FREQ4 = 3'd5;
   localparam logic [2:0] SEL_CTL   = 3'd6;

   // Number of per-voice tables (four frequency tables and the control table).
   localparam int VOICE_TABLES = 5;
   localparam logic [2:0] VTAB_FREQ1 = 3'd0;
   localparam logic [2:0] VTAB_FREQ2 = 3'd1;
   localparam logic [2:0] VTAB_FREQ3 = 3'd2;
   localparam logic [2:0] VTAB_FREQ4 = 3'd3;
   localparam logic [2:0] VTAB_CTL   = 3'd4;

   // Classified operation codes passed from the front to the back.
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_STEP     = 3'd1;
   localparam logic [2:0] OP_WR_SEQ   = 3'd2;
   localparam logic [2:0] OP_WR_DUR   = 3'd3;
   localparam logic [2:0] OP_WR_VOICE = 3'd4;

   // Sound chip register offsets.
   localparam logic [2:0] REG_FREQ1 = 3'd0;
   localparam logic [2:0] REG_AMP1  = 3'd1;
   localparam logic [2:0] REG_FREQ2 = 3'd2;
   localparam logic [2:0] REG_AMP2  = 3'd3;
   localparam logic [2:0] REG_FREQ3 = 3'd4;
   localparam logic [2:0] REG_AMP3  = 3'd5;
   localparam logic [2:0] REG_FREQ4 = 3'd6;
   localparam logic [2:0] REG_CTL4  = 3'd7;

   // Amplitude constants.
   localparam logic [7:0] AMP_BASE  = 8'hA0;
   localparam logic [7:0] AMP_MAX   = 8'hA3;
   localparam logic [7:0] AMP_BOOST = 8'd2;
   localparam logic [6:0] AMP_HALF_LIMIT = 7'd3;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] vsel;
      logic [7:0] addr;
      logic [7:0] data;
   } tsp_op_type;

   // Remainder of a byte by a constant modulus of at least 8, taken by
   // restoring shift-and-subtract over five steps.
   function automatic logic [7:0] mod_small(input logic [7:0] value,
                                            input logic [8:0] modulus);
      logic [12:0] rem;
      logic [12:0] sub;
      rem = {5'd0, value};
      for (int k = 4; k >= 0; k--) begin
         sub = {4'd0, modulus} << k;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[7:0];
   endfunction

endpackage

`default_nettype wire

### src/tsp_if.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface tsp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [2:0] table_select;
   logic [7:0] table_index;
   logic [7:0] table_data;

   modport source (output valid, output func, output table_select,
                   output table_index, output table_data, input ready);
   modport sink   (input valid, input func, input table_select,
                   input table_index, input table_data, output ready);
endinterface

interface tsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] reg_offset;
   logic [7:0] reg_data;
   logic       last;

   modport source (output valid, output reg_offset, output reg_data,
                   output last, input ready);
   modport sink   (input valid, input reg_offset, input reg_data,
                   input last, output ready);
endinterface

`default_nettype wire

### src/tsp_front.sv
// Front stage: accepts request words, classifies them and drops ignored ones.
`default_nettype none

module tsp_front #(
   parameter int SEQ_DEPTH     = tsp_pkg::DEF_SEQ_DEPTH,
   parameter int VOICE_ENTRIES = tsp_pkg::DEF_VOICE_ENTRIES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   tsp_req_if.sink           req_bus,
   output logic              push_valid,
   input  wire logic         push_ready,
   output tsp_pkg::tsp_op_type push_op
);

   logic                front_v_ff, front_v_in;
   tsp_pkg::tsp_op_type front_op_ff, front_op_in;
   tsp_pkg::tsp_op_type cls_op;
   logic                cls_keep;
   logic                accept;
   logic                idx_in_range;

   assign req_bus.ready = !front_v_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign idx_in_range  = ({1'b0, req_bus.table_index} < 9'(VOICE_ENTRIES));

   always_comb begin
      cls_keep      = 1'b0;
      cls_op.kind   = tsp_pkg::OP_TICK;
      cls_op.vsel   = 3'(req_bus.table_select - tsp_pkg::SEL_FREQ1);
      cls_op.addr   = req_bus.table_index;
      cls_op.data   = req_bus.table_data;
      case (req_bus.func)
         tsp_pkg::FUNC_TICK: begin
            cls_keep    = 1'b1;
            cls_op.kind = tsp_pkg::OP_TICK;
         end
         tsp_pkg::FUNC_STEP: begin
            cls_keep    = 1'b1;
            cls_op.kind = tsp_pkg::OP_STEP;
         end
         tsp_pkg::FUNC_WRITE: begin
            case (req_bus.table_select)
               tsp_pkg::SEL_SEQ: begin
                  cls_keep    = 1'b1;
                  cls_op.kind = tsp_pkg::OP_WR_SEQ;
                  cls_op.addr = tsp_pkg::mod_small(req_bus.table_index, 9'(SEQ_DEPTH));
               end
               tsp_pkg::SEL_DUR: begin
                  cls_keep    = idx_in_range;
                  cls_op.kind = tsp_pkg::OP_WR_DUR;
               end
               tsp_pkg::SEL_FREQ1, tsp_pkg::SEL_FREQ2, tsp_pkg::SEL_FREQ3,
               tsp_pkg::SEL_FREQ4, tsp_pkg::SEL_CTL: begin
                  cls_keep    = idx_in_range;
                  cls_op.kind = tsp_pkg::OP_WR_VOICE;
               end
               default: begin
                  cls_keep = 1'b0;
               end
            endcase
         end
         default: begin
            cls_keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      front_v_in  = front_v_ff && !push_ready;
      front_op_in = front_op_ff;
      if (accept) begin
         front_v_in  = cls_keep;
         front_op_in = cls_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
      front_op_ff <= front_op_in;
   end

   assign push_valid = front_v_ff;
   assign push_op    = front_op_ff;

endmodule

`default_nettype wire

### src/tsp_queue.sv
// Two-entry queue of classified operations between the front and the back.
`default_nettype none

module tsp_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  tsp_pkg::tsp_op_type push_op,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output tsp_pkg::tsp_op_type pop_op
);

   tsp_pkg::tsp_op_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

### src/tsp_back.sv
// Back stage: table stores, sequence walker, tick amplitude writer and output register.
`default_nettype none

module tsp_back #(
   parameter int SEQ_DEPTH     = tsp_pkg::DEF_SEQ_DEPTH,
   parameter int VOICE_ENTRIES = tsp_pkg::DEF_VOICE_ENTRIES,
   parameter int MAX_COMMANDS  = tsp_pkg::DEF_MAX_COMMANDS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         op_valid,
   output logic              op_ready,
   input  tsp_pkg::tsp_op_type op,
   tsp_rsp_if.source         rsp_bus
);

   localparam int SEQ_AW   = $clog2(SEQ_DEPTH);
   localparam int VOICE_AW = $clog2(VOICE_ENTRIES);
   localparam int CMD_W    = $clog2(MAX_COMMANDS + 1);
   localparam logic [SEQ_AW-1:0] SEQ_LAST = SEQ_AW'(SEQ_DEPTH - 1);
   localparam logic [CMD_W-1:0]  CMD_LAST = CMD_W'(MAX_COMMANDS - 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_BYTE = 4'd1;
   localparam logic [3:0] ST_V0   = 4'd2;
   localparam logic [3:0] ST_V1   = 4'd3;
   localparam logic [3:0] ST_V2   = 4'd4;
   localparam logic [3:0] ST_V3   = 4'd5;
   localparam logic [3:0] ST_V4   = 4'd6;
   localparam logic [3:0] ST_END  = 4'd7;
   localparam logic [3:0] ST_AMP0 = 4'd8;
   localparam logic [3:0] ST_AMP1 = 4'd9;
   localparam logic [3:0] ST_AMP2 = 4'd10;
   localparam logic [3:0] ST_AMP3 = 4'd11;
   localparam logic [3:0] ST_FIN  = 4'd12;

   // Stores.
   logic [7:0] seq_mem   [SEQ_DEPTH];
   logic [7:0] dur_mem   [VOICE_ENTRIES];
   logic [7:0] voice_mem [tsp_pkg::VOICE_TABLES][VOICE_ENTRIES];
   logic [7:0] seq_q;
   logic [7:0] dur_q;
   logic [7:0] voice_q   [tsp_pkg::VOICE_TABLES];

   logic [3:0]          state_ff, state_in;
   logic [SEQ_AW-1:0]   ptr_ff, ptr_in, ptr_next;
   logic [7:0]          dur_ff, dur_in, dec;
   logic [2:0]          gate_ff, gate_in;
   logic [6:0]          note_ff, note_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic                reread_ff, reread_in;
   logic                tick_ff, tick_in;
   logic [VOICE_AW-1:0] v_ff, v_in, v_calc, dur_addr;
   logic [7:0]          v_mod, dur_mod;

   logic       pend_v_ff, pend_v_in;
   logic [2:0] pend_off_ff, pend_off_in;
   logic [7:0] pend_data_ff, pend_data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_off_ff, rsp_off_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       prod, fin, can_go, out_free, take_op;
   logic [2:0] prod_off;
   logic [7:0] prod_data;
   logic [6:0] half;
   logic [7:0] amp;

   assign take_op  = (state_ff == ST_IDLE) && op_valid;
   assign ptr_next = (ptr_ff == SEQ_LAST) ? '0 : ptr_ff + 1'b1;
   assign dec      = dur_ff - 8'd1;
   assign v_mod    = tsp_pkg::mod_small({3'b000, seq_q[4:0]}, 9'(VOICE_ENTRIES));
   assign v_calc   = v_mod[VOICE_AW-1:0];
   assign v_in     = (state_ff == ST_BYTE) ? v_calc : v_ff;
   assign dur_mod  = tsp_pkg::mod_small({3'b000, note_in[4:0]}, 9'(VOICE_ENTRIES));
   assign dur_addr = dur_mod[VOICE_AW-1:0];
   assign half     = dur_ff[7:1];
   assign amp      = (half < tsp_pkg::AMP_HALF_LIMIT) ? tsp_pkg::AMP_BASE + 8'(half)
                                                      : tsp_pkg::AMP_MAX;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign can_go   = !pend_v_ff || out_free;

   // Table writes happen only while idle; reads are registered every cycle.
   // The sequence store is read at the next pointer value so that its output
   // always shows the entry under the pointer register.
   always_ff @(posedge clock) begin
      if (take_op && op.kind == tsp_pkg::OP_WR_SEQ) begin
         seq_mem[op.addr[SEQ_AW-1:0]] <= op.data;
      end
      if (take_op && op.kind == tsp_pkg::OP_WR_DUR) begin
         dur_mem[op.addr[VOICE_AW-1:0]] <= op.data;
      end
      if (take_op && op.kind == tsp_pkg::OP_WR_VOICE) begin
         voice_mem[op.vsel][op.addr[VOICE_AW-1:0]] <= op.data;
      end
      seq_q <= seq_mem[ptr_in];
      dur_q <= dur_mem[dur_addr];
      for (int k = 0; k < tsp_pkg::VOICE_TABLES; k++) begin
         voice_q[k] <= voice_mem[k][v_in];
      end
   end

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      dur_in    = dur_ff;
      gate_in   = gate_ff;
      note_in   = note_ff;
      cmd_in    = cmd_ff;
      reread_in = reread_ff;
      tick_in   = tick_ff;
      op_ready  = 1'b0;
      prod      = 1'b0;
      fin       = 1'b0;
      prod_off  = tsp_pkg::REG_FREQ1;
      prod_data = 8'd0;
      case (state_ff)
         ST_IDLE: begin
            op_ready  = 1'b1;
            cmd_in    = '0;
            reread_in = 1'b0;
            if (op_valid) begin
               case (op.kind)
                  tsp_pkg::OP_TICK: begin
                     dur_in = dec;
                     if (dec[7]) begin
                        tick_in  = 1'b1;
                        ptr_in   = ptr_next;
                        state_in = ST_BYTE;
                     end else begin
                        state_in = ST_AMP0;
                     end
                  end
                  tsp_pkg::OP_STEP: begin
                     tick_in  = 1'b0;
                     ptr_in   = ptr_next;
                     state_in = ST_BYTE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BYTE: begin
            if (seq_q == 8'd0 && !reread_ff) begin
               // End of sequence marker: go back to the first entry.
               reread_in = 1'b1;
               ptr_in    = '0;
            end else if (!seq_q[7]) begin
               note_in  = seq_q[6:0];
               state_in = ST_END;
            end else begin
               state_in = ST_V0;
            end
         end
         ST_V0: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_FREQ1;
            prod_data = voice_q[tsp_pkg::VTAB_FREQ1];
            if (can_go) state_in = ST_V1;
         end
         ST_V1: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_FREQ2;
            prod_data = voice_q[tsp_pkg::VTAB_FREQ2];
            if (can_go) state_in = ST_V2;
         end
         ST_V2: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_FREQ3;
            prod_data = voice_q[tsp_pkg::VTAB_FREQ3];
            if (can_go) state_in = ST_V3;
         end
         ST_V3: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_FREQ4;
            prod_data = voice_q[tsp_pkg::VTAB_FREQ4];
            if (can_go) state_in = ST_V4;
         end
         ST_V4: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_CTL4;
            prod_data = voice_q[tsp_pkg::VTAB_CTL];
            if (can_go) begin
               cmd_in = cmd_ff + 1'b1;
               if (voice_q[tsp_pkg::VTAB_CTL] == 8'd0 || cmd_ff == CMD_LAST) begin
                  // Silent control or command cap reached: finish as a rest.
                  note_in  = '0;
                  state_in = ST_END;
               end else begin
                  reread_in = 1'b0;
                  ptr_in    = ptr_next;
                  state_in  = ST_BYTE;
               end
            end
         end
         ST_END: begin
            dur_in   = dur_q;
            gate_in  = note_ff[6:4];
            state_in = tick_ff ? ST_AMP0 : ST_FIN;
         end
         ST_AMP0: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_AMP1;
            prod_data = (gate_ff == 3'd0) ? 8'd0 : amp;
            if (can_go) state_in = ST_AMP1;
         end
         ST_AMP1: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_AMP2;
            prod_data = (gate_ff == 3'd0) ? 8'd0 : amp;
            if (can_go) state_in = ST_AMP2;
         end
         ST_AMP2: begin
            prod      = 1'b1;
            prod_off  = tsp_pkg::REG_AMP3;
            prod_data = (gate_ff == 3'd0) ? 8'd0 : amp;
            if (can_go) state_in = (gate_ff == 3'd0) ? ST_FIN : ST_AMP3;
         end
         ST_AMP3: begin
            prod      = 1'b1;
            prod_off  = 3'(gate_ff - 3'd1);
            prod_data = amp + tsp_pkg::AMP_BOOST;
            if (can_go) state_in = ST_FIN;
         end
         ST_FIN: begin
            fin = 1'b1;
            if (can_go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A produced word waits in the pending register until the next one shows
   // up or the item ends, so that the last flag is known when it moves on.
   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_off_in  = pend_off_ff;
      pend_data_in = pend_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_off_in   = rsp_off_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (can_go && (prod || fin)) begin
         if (pend_v_ff) begin
            rsp_valid_in = 1'b1;
            rsp_off_in   = pend_off_ff;
            rsp_data_in  = pend_data_ff;
            rsp_last_in  = fin;
         end
         pend_v_in    = prod;
         pend_off_in  = prod_off;
         pend_data_in = prod_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         dur_ff       <= 8'd0;
         gate_ff      <= 3'd0;
         note_ff      <= '0;
         cmd_ff       <= '0;
         reread_ff    <= 1'b0;
         tick_ff      <= 1'b0;
         v_ff         <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         dur_ff       <= dur_in;
         gate_ff      <= gate_in;
         note_ff      <= note_in;
         cmd_ff       <= cmd_in;
         reread_ff    <= reread_in;
         tick_ff      <= tick_in;
         v_ff         <= v_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_off_ff  <= pend_off_in;
      pend_data_ff <= pend_data_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.reg_offset = rsp_off_ff;
   assign rsp_bus.reg_data   = rsp_data_ff;
   assign rsp_bus.last       = rsp_last_ff;

endmodule

`default_nettype wire

### src/tone_sequence_player_core.sv
// Top level of the tone sequence player: front classifier, queue and back sequencer.
//
//   channel   direction   handshake            word contents
//   req_bus   in          valid/ready          func, table_select, table_index, table_data
//   rsp_bus   out         valid/ready          reg_offset, reg_data, last
//
// A table write word is done in the back as it leaves the queue; the back stays idle.
// A tick without a sequence step emits three or four amplitude words and then
// closes the item; every command in a step walk adds one sequence store read
// and five voice register words, and the walk ends by loading the duration of
// its note or rest. The sequence store is read once per walked byte, and the
// output register takes one word per cycle while rsp_bus is ready.
// Reset is synchronous; it clears the duration counter, gate, sequence
// pointer and all handshake state, while the table stores keep their data.
// The front keeps taking words into the queue, until it is full, while the back
// works or the response side stalls; a stall on rsp_bus holds the back in place.
`default_nettype none

module tone_sequence_player_core #(
   parameter int SEQ_DEPTH     = tsp_pkg::DEF_SEQ_DEPTH,
   parameter int VOICE_ENTRIES = tsp_pkg::DEF_VOICE_ENTRIES,
   parameter int MAX_COMMANDS  = tsp_pkg::DEF_MAX_COMMANDS
) (
   input  wire logic clock,
   input  wire logic reset,
   tsp_req_if.sink   req_bus,
   tsp_rsp_if.source rsp_bus
);

   // Front to queue.
   logic                q_push_valid;
   logic                q_push_ready;
   tsp_pkg::tsp_op_type q_push_op;

   // Queue to back.
   logic                q_pop_valid;
   logic                q_pop_ready;
   tsp_pkg::tsp_op_type q_pop_op;

   tsp_front #(
      .SEQ_DEPTH     (SEQ_DEPTH),
      .VOICE_ENTRIES (VOICE_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_op    (q_push_op)
   );

   tsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_op    (q_push_op),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_op     (q_pop_op)
   );

   // The back owns every store, so table writes stay in order with the
   // reads of the steps around them.
   tsp_back #(
      .SEQ_DEPTH     (SEQ_DEPTH),
      .VOICE_ENTRIES (VOICE_ENTRIES),
      .MAX_COMMANDS  (MAX_COMMANDS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (q_pop_valid),
      .op_ready (q_pop_ready),
      .op       (q_pop_op),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the tone sequence player core: directed table, then random words.

module testbench;
   import tsp_pkg::*;

   // The bench models the block at its default sizes.
   localparam int SEQ_DEPTH     = DEF_SEQ_DEPTH;
   localparam int VOICE_ENTRIES = DEF_VOICE_ENTRIES;
   localparam int MAX_COMMANDS  = DEF_MAX_COMMANDS;

   // Codes the block has no use for; words carrying them are dropped by the block.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [2:0] SEL_UNUSED  = 3'd7;

   // Number of words that do real work (ticks, steps, table writes) in the run.
   localparam int WORK_WORDS = 220;

   // The longest correct quiet stretch is a capped command walk behind a long
   // run of receiver stalls; this limit is many times that.
   localparam int IDLE_LIMIT = 2000;

   // Cycles to keep watching after the last expected write, enough for one more
   // full walk to show up if the block emitted writes that nobody asked for.
   localparam int DRAIN_CYCLES = 120;

   // One register write of the sound chip, as it leaves the block.
   typedef struct packed {
      logic [2:0] offset;
      logic [7:0] data;
      logic       last;
   } chip_write_t;

   // One row of the directed table. Rows with typed set carry their expected
   // writes as {offset, data} pairs; last is implied on the final one.
   typedef struct packed {
      logic [1:0]        func;
      logic [2:0]        sel;
      logic [7:0]        idx;
      logic [7:0]        data;
      logic              typed;
      logic [2:0]        n_writes;
      logic [0:4][10:0]  writes;
   } play_row_t;

   localparam logic [0:4][10:0] NO_WRITES = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsp_req_if req_bus ();
   tsp_rsp_if rsp_bus ();

   tone_sequence_player_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow state of the sequencer. The *_set arrays record which table
   // entries have been written, so that no walk is ever sent into an
   // entry whose contents are undefined.
   // ------------------------------------------------------------------
   logic [7:0] dur_count;
   logic [2:0] gate;
   logic [7:0] seq_ptr;
   logic [7:0] seq_mem   [SEQ_DEPTH];
   bit         seq_set   [SEQ_DEPTH];
   logic [7:0] dur_mem   [VOICE_ENTRIES];
   bit         dur_set   [VOICE_ENTRIES];
   logic [7:0] voice_mem [VOICE_TABLES][VOICE_ENTRIES];
   bit         voice_set [VOICE_TABLES][VOICE_ENTRIES];

   chip_write_t item_writes[$];     // writes caused by the word just accepted
   chip_write_t pending_writes[$];  // writes still owed by the block, oldest first

   int errors = 0;
   int work_words = 0;
   int send_idle_pct;
   int recv_stall_pct;
   int idle_cycles = 0;

   play_row_t play_rows[$];

   function automatic logic [10:0] wr(input logic [2:0] off, input logic [7:0] d);
      return {off, d};
   endfunction

   function automatic play_row_t mk_row(input logic [1:0] f, input logic [2:0] s,
                                        input logic [7:0] i, input logic [7:0] d,
                                        input logic typed, input logic [2:0] n,
                                        input logic [0:4][10:0] w);
      play_row_t r;
      r.func = f;
      r.sel = s;
      r.idx = i;
      r.data = d;
      r.typed = typed;
      r.n_writes = n;
      r.writes = w;
      return r;
   endfunction

   function automatic void note_write(input logic [2:0] off, input logic [7:0] d);
      chip_write_t w;
      w.offset = off;
      w.data = d;
      w.last = 1'b0;
      item_writes.push_back(w);
   endfunction

   // A sequence step: walk forward through the sequence, emitting the voice
   // registers of every command byte, until a note or a rest ends the walk.
   function automatic void walk_sequence();
      logic [7:0] ptr;
      logic [7:0] b;
      logic [7:0] note;
      logic [7:0] v;
      int         cmds;
      ptr = seq_ptr;
      note = 8'd0;
      cmds = 0;
      while (1) begin
         ptr = 8'((ptr + 1) % SEQ_DEPTH);
         b = seq_mem[ptr];
         // A zero byte sends the pointer home and the home entry is read instead.
         if (b == 8'd0) begin
            ptr = 8'd0;
            b = seq_mem[0];
         end
         if (!b[7]) begin
            note = b;
            break;
         end
         v = 8'((b & 8'h1F) % VOICE_ENTRIES);
         note_write(REG_FREQ1, voice_mem[VTAB_FREQ1][v]);
         note_write(REG_FREQ2, voice_mem[VTAB_FREQ2][v]);
         note_write(REG_FREQ3, voice_mem[VTAB_FREQ3][v]);
         note_write(REG_FREQ4, voice_mem[VTAB_FREQ4][v]);
         note_write(REG_CTL4, voice_mem[VTAB_CTL][v]);
         cmds++;
         // A silent control value, or the command cap, turns the walk into a rest.
         if (voice_mem[VTAB_CTL][v] == 8'd0 || cmds >= MAX_COMMANDS) begin
            note = 8'd0;
            break;
         end
      end
      seq_ptr = ptr;
      dur_count = dur_mem[(note & 8'h1F) % VOICE_ENTRIES];
      gate = note[6:4];
   endfunction

   // Predicts the register writes of one accepted word and advances the shadow state.
   function automatic void play_word(input logic [1:0] func, input logic [2:0] sel,
                                     input logic [7:0] idx, input logic [7:0] data);
      logic [6:0] half;
      logic [7:0] amp;
      item_writes.delete();
      case (func)
         FUNC_WRITE: begin
            if (sel == SEL_SEQ) begin
               seq_mem[idx % SEQ_DEPTH] = data;
               seq_set[idx % SEQ_DEPTH] = 1'b1;
            end else if (sel == SEL_DUR && idx < VOICE_ENTRIES) begin
               dur_mem[idx] = data;
               dur_set[idx] = 1'b1;
            end else if (sel >= SEL_FREQ1 && sel <= SEL_CTL && idx < VOICE_ENTRIES) begin
               voice_mem[sel - SEL_FREQ1][idx] = data;
               voice_set[sel - SEL_FREQ1][idx] = 1'b1;
            end
         end
         FUNC_STEP: begin
            walk_sequence();
         end
         FUNC_TICK: begin
            dur_count = dur_count - 8'd1;
            if (dur_count[7]) begin
               walk_sequence();
            end
            half = dur_count[7:1];
            amp = (half < AMP_HALF_LIMIT) ? AMP_BASE + 8'(half) : AMP_MAX;
            if (gate == 3'd0) begin
               note_write(REG_AMP1, 8'd0);
               note_write(REG_AMP2, 8'd0);
               note_write(REG_AMP3, 8'd0);
            end else begin
               note_write(REG_AMP1, amp);
               note_write(REG_AMP2, amp);
               note_write(REG_AMP3, amp);
               note_write(gate - 3'd1, amp + AMP_BOOST);
            end
         end
         default: begin
         end
      endcase
      if (item_writes.size() > 0) begin
         item_writes[item_writes.size() - 1].last = 1'b1;
      end
   endfunction

   // Dry run of the walk that a tick or step would start. Returns 1 with the
   // first table entry it would read before that entry was ever written.
   function automatic bit find_unwritten(input logic [1:0] func, output logic [2:0] sel,
                                         output logic [7:0] idx);
      logic [7:0] ptr;
      logic [7:0] b;
      logic [7:0] cnt;
      logic [7:0] v;
      int         cmds;
      if (func == FUNC_TICK) begin
         cnt = dur_count - 8'd1;
         if (!cnt[7]) begin
            return 1'b0;
         end
      end else if (func != FUNC_STEP) begin
         return 1'b0;
      end
      ptr = seq_ptr;
      cmds = 0;
      while (1) begin
         ptr = 8'((ptr + 1) % SEQ_DEPTH);
         if (!seq_set[ptr]) begin
            sel = SEL_SEQ;
            idx = ptr;
            return 1'b1;
         end
         b = seq_mem[ptr];
         if (b == 8'd0) begin
            ptr = 8'd0;
            if (!seq_set[0]) begin
               sel = SEL_SEQ;
               idx = 8'd0;
               return 1'b1;
            end
            b = seq_mem[0];
         end
         if (!b[7]) begin
            v = 8'((b & 8'h1F) % VOICE_ENTRIES);
            break;
         end
         v = 8'((b & 8'h1F) % VOICE_ENTRIES);
         for (int k = 0; k < VOICE_TABLES; k++) begin
            if (!voice_set[k][v]) begin
               sel = SEL_FREQ1 + 3'(k);
               idx = v;
               return 1'b1;
            end
         end
         cmds++;
         if (voice_mem[VTAB_CTL][v] == 8'd0 || cmds >= MAX_COMMANDS) begin
            v = 8'd0;
            break;
         end
      end
      if (!dur_set[v]) begin
         sel = SEL_DUR;
         idx = v;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Table contents shaped so that walks go deep: sequence bytes are mostly
   // notes and commands with a few loop markers, control values are mostly
   // nonzero, and durations are mostly short so that steps come often.
   function automatic logic [7:0] table_byte(input logic [2:0] sel);
      int r;
      r = $urandom_range(0, 99);
      case (sel)
         SEL_SEQ: begin
            if (r < 8) return 8'd0;
            if (r < 50) return 8'($urandom_range(1, 127));
            return 8'($urandom_range(128, 255));
         end
         SEL_DUR: begin
            if (r < 80) return 8'($urandom_range(0, 7));
            return 8'($urandom_range(0, 255));
         end
         SEL_CTL: begin
            if (r < 20) return 8'd0;
            return 8'($urandom_range(1, 255));
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Drives one word onto the request channel and returns at the rising edge
   // that accepts it. Fields change only at falling edges, and valid gets at
   // most one assignment per edge.
   task automatic send_word(input logic [1:0] func, input logic [2:0] sel,
                            input logic [7:0] idx, input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.table_select <= sel;
      req_bus.table_index <= idx;
      req_bus.table_data <= data;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Sends a word and queues the writes the shadow model predicts for it.
   task automatic deliver(input logic [1:0] func, input logic [2:0] sel,
                          input logic [7:0] idx, input logic [7:0] data);
      send_word(func, sel, idx, data);
      play_word(func, sel, idx, data);
      foreach (item_writes[k]) begin
         pending_writes.push_back(item_writes[k]);
      end
   endtask

   // Sends a word, first filling any table entry its walk would read unwritten.
   task automatic issue(input logic [1:0] func, input logic [2:0] sel,
                        input logic [7:0] idx, input logic [7:0] data);
      logic [2:0] gap_sel;
      logic [7:0] gap_idx;
      while (find_unwritten(func, gap_sel, gap_idx)) begin
         deliver(FUNC_WRITE, gap_sel, gap_idx, table_byte(gap_sel));
         work_words++;
      end
      deliver(func, sel, idx, data);
   endtask

   // Three stretches of back pressure: a slow receiver, then a slow sender,
   // then both sides at full speed.
   task automatic pick_pressure();
      if (work_words < WORK_WORDS / 3) begin
         send_idle_pct = 25;
         recv_stall_pct = 63;
      end else if (work_words < 2 * WORK_WORDS / 3) begin
         send_idle_pct = 63;
         recv_stall_pct = 25;
      end else begin
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end
   endtask

   // The receiver decides at each falling edge whether it takes a word at
   // the next rising edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Every register write that leaves the block is matched against the
   // oldest write still owed.
   always @(posedge clock) begin
      chip_write_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected register write: offset %0d data %02h last %b",
                     $time, rsp_bus.reg_offset, rsp_bus.reg_data, rsp_bus.last);
            errors++;
         end else begin
            want = pending_writes.pop_front();
            if (want.offset !== rsp_bus.reg_offset || want.data !== rsp_bus.reg_data ||
                want.last !== rsp_bus.last) begin
               $display("%0t: write mismatch: expected offset %0d data %02h last %b, got offset %0d data %02h last %b",
                        $time, want.offset, want.data, want.last,
                        rsp_bus.reg_offset, rsp_bus.reg_data, rsp_bus.last);
               errors++;
            end
         end
      end
   end

   // Watchdog: a long stretch with no word moving on either channel means
   // the block has hung.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         r;
      logic [1:0] func;
      logic [2:0] sel;
      logic [7:0] idx;
      logic [7:0] data;
      chip_write_t w;

      req_bus.valid = 1'b0;
      req_bus.func = FUNC_TICK;
      req_bus.table_select = SEL_SEQ;
      req_bus.table_index = 8'd0;
      req_bus.table_data = 8'd0;
      rsp_bus.ready = 1'b0;

      dur_count = 8'd0;
      gate = 3'd0;
      seq_ptr = 8'd0;
      foreach (seq_set[i]) seq_set[i] = 1'b0;
      foreach (dur_set[i]) dur_set[i] = 1'b0;
      foreach (voice_set[t, i]) voice_set[t][i] = 1'b0;

      send_idle_pct = 25;
      recv_stall_pct = 63;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Voice 31 is set up with extreme frequency values and,
      // later, a nonzero control value; the sequence 0xFF, 0xFF, 0x00 then
      // loops on commands until the command cap forces a rest.
      play_rows = '{
         // Home entry is a zero byte, so a wrap lands on a rest of duration 5.
         mk_row(FUNC_WRITE, SEL_SEQ, 8'd0, 8'h00, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_DUR, 8'd0, 8'h05, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_SEQ, 8'd1, 8'h00, 1'b0, 3'd0, NO_WRITES),
         // First tick after reset: the counter wraps below zero and steps.
         // The walk wraps home to a rest, so the gate is closed.
         mk_row(FUNC_TICK, SEL_SEQ, 8'd0, 8'h00, 1'b1, 3'd3,
                {wr(REG_AMP1, 8'h00), wr(REG_AMP2, 8'h00), wr(REG_AMP3, 8'h00),
                 11'd0, 11'd0}),
         // A step that meets no command emits nothing.
         mk_row(FUNC_STEP, SEL_SEQ, 8'd0, 8'h00, 1'b1, 3'd0, NO_WRITES),
         // Words the block must drop: unused function, unused table, and
         // an index past the end of the duration table.
         mk_row(FUNC_UNUSED, SEL_UNUSED, 8'hFF, 8'hFF, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_UNUSED, 8'd0, 8'hFF, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_DUR, 8'hFF, 8'hFF, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_FREQ1, 8'd31, 8'hFF, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_FREQ2, 8'd31, 8'h00, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_FREQ3, 8'd31, 8'h80, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_FREQ4, 8'd31, 8'h01, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_CTL, 8'd31, 8'h00, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_DUR, 8'd31, 8'h80, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_SEQ, 8'd1, 8'hFF, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_SEQ, 8'd2, 8'h7F, 1'b0, 3'd0, NO_WRITES),
         // A command with a silent control value: one voice, then a rest.
         mk_row(FUNC_STEP, SEL_SEQ, 8'd0, 8'h00, 1'b1, 3'd5,
                {wr(REG_FREQ1, 8'hFF), wr(REG_FREQ2, 8'h00), wr(REG_FREQ3, 8'h80),
                 wr(REG_FREQ4, 8'h01), wr(REG_CTL4, 8'h00)}),
         // The largest note: duration 0x80 and the widest gate.
         mk_row(FUNC_STEP, SEL_SEQ, 8'd0, 8'h00, 1'b1, 3'd0, NO_WRITES),
         // Long duration, so the amplitude sits at its cap and the gated
         // register gets the boosted value.
         mk_row(FUNC_TICK, SEL_SEQ, 8'd0, 8'h00, 1'b1, 3'd4,
                {wr(REG_AMP1, 8'hA3), wr(REG_AMP2, 8'hA3), wr(REG_AMP3, 8'hA3),
                 wr(REG_FREQ4, 8'hA5), 11'd0}),
         mk_row(FUNC_WRITE, SEL_CTL, 8'd31, 8'h01, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_SEQ, 8'd0, 8'hFF, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_SEQ, 8'd2, 8'h00, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_SEQ, 8'd3, 8'h00, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_WRITE, SEL_SEQ, 8'hFF, 8'h80, 1'b0, 3'd0, NO_WRITES),
         // Endless command loop, cut by the command cap.
         mk_row(FUNC_STEP, SEL_SEQ, 8'd0, 8'h00, 1'b0, 3'd0, NO_WRITES),
         mk_row(FUNC_TICK, SEL_SEQ, 8'd0, 8'h00, 1'b0, 3'd0, NO_WRITES)
      };

      foreach (play_rows[n]) begin
         pick_pressure();
         if (play_rows[n].typed) begin
            send_word(play_rows[n].func, play_rows[n].sel, play_rows[n].idx,
                      play_rows[n].data);
            play_word(play_rows[n].func, play_rows[n].sel, play_rows[n].idx,
                      play_rows[n].data);
            for (int k = 0; k < play_rows[n].n_writes; k++) begin
               w.offset = play_rows[n].writes[k][10:8];
               w.data = play_rows[n].writes[k][7:0];
               w.last = (k == play_rows[n].n_writes - 1);
               pending_writes.push_back(w);
            end
         end else begin
            issue(play_rows[n].func, play_rows[n].sel, play_rows[n].idx, play_rows[n].data);
         end
         work_words++;
      end

      // Random part: mostly ticks and steps over randomly grown tables, with
      // table rewrites at any index and a little noise of dropped words.
      while (work_words < WORK_WORDS) begin
         pick_pressure();
         r = $urandom_range(0, 99);
         if (r < 50) begin
            issue(FUNC_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
            work_words++;
         end else if (r < 65) begin
            issue(FUNC_STEP, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
            work_words++;
         end else if (r < 93) begin
            sel = 3'($urandom_range(0, 6));
            if (sel == SEL_SEQ || $urandom_range(0, 3) == 0) begin
               idx = 8'($urandom_range(0, 255));
            end else begin
               idx = 8'($urandom_range(0, VOICE_ENTRIES - 1));
            end
            data = ($urandom_range(0, 9) < 7) ? table_byte(sel) : 8'($urandom_range(0, 255));
            issue(FUNC_WRITE, sel, idx, data);
            work_words++;
         end else begin
            func = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED : FUNC_WRITE;
            issue(func, SEL_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (pending_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && pending_writes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
